@@ design/iws_pkg.sv @@
// ----------------------------------------------------------------------------
// iws_pkg
// Shared types, register indexes and constants for the interval watering
// sequencer.
// ----------------------------------------------------------------------------
package iws_pkg;

  // Sample and field widths
  localparam int unsigned SampleW  = 10;
  localparam int unsigned PctW     = 7;
  localparam int unsigned SecW     = 17;
  localparam int unsigned DurW     = 20;
  localparam int unsigned SettleW  = 16;
  localparam int unsigned ReasonW  = 2;

  // Converter resolution; bits above it are ignored on both samples.
  localparam int unsigned AdcBits  = 10;
  localparam logic [SampleW-1:0] AdcMask = SampleW'((32'd1 << AdcBits) - 32'd1);

  // Moisture map: raw DryRaw..WetRaw -> 0..FullPct percent.
  // (raw - DryRaw) * 100 / 580 == (raw - DryRaw) * 5 / 29; the 5/29 factor is
  // taken as a multiply by ceil(5 * 2^16 / 29) and a shift, exact for all
  // offsets below 580.
  localparam logic [SampleW-1:0] DryRaw   = SampleW'(300);
  localparam logic [SampleW-1:0] WetRaw   = SampleW'(880);
  localparam logic [PctW-1:0]    FullPct  = PctW'(100);
  localparam int unsigned        PctShift = 16;
  localparam int unsigned        PctRecip = 11300;
  localparam int unsigned        ProdW    = SampleW + 14;

  // Millisecond sub-counter
  localparam int unsigned        MsPerS = 1000;
  localparam int unsigned        MsW    = $clog2(MsPerS);
  localparam logic [MsW-1:0]     MsLast = MsW'(MsPerS - 1);

  // Stream payload widths, padded to whole bytes
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 32;

  // Configuration port
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    RegAutoEnable  = 3'd0,
    RegInterval    = 3'd1,
    RegDuration    = 3'd2,
    RegSettle      = 3'd3,
    RegWaterThresh = 3'd4,
    RegWetLimit    = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhLead  = 2'd1,
    PhPump  = 2'd2,
    PhTrail = 2'd3
  } phase_e;

  typedef enum logic [ReasonW-1:0] {
    SkipNone     = 2'd0,
    SkipWet      = 2'd1,
    SkipStanding = 2'd2
  } skip_e;

  // Phase after p, passing over phases of zero length.
  function automatic phase_e next_phase(phase_e p, logic settle_zero, logic pump_zero);
    phase_e n;
    n = PhIdle;
    unique case (p)
      PhIdle: begin
        if (!settle_zero) n = PhLead;
        else if (!pump_zero) n = PhPump;
        else n = PhIdle;
      end
      PhLead: begin
        if (!pump_zero) n = PhPump;
        else if (!settle_zero) n = PhTrail;
        else n = PhIdle;
      end
      PhPump: begin
        if (!settle_zero) n = PhTrail;
        else n = PhIdle;
      end
      PhTrail: n = PhIdle;
      default: n = PhIdle;
    endcase
    return n;
  endfunction

endpackage

@@ design/interval_watering_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// interval_watering_sequencer_unit
// Millisecond-tick irrigation scheduler: interval timer, moisture and
// standing-water checks, valve/pump sequencing.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              payload
//  --------  ---  ---------------------  ----------------------------------------
//  s_axis    in   tvalid / tready        tdata: soil_sample, standing_water_sample
//  m_axis    out  tvalid / tready        tdata: valve, pump, pct, secs, reason;
//                                        tlast: cycle_done
//  apb       in   psel/penable/pwrite    paddr, pwdata, prdata, pready (always 1)
//
//  One beat in gives one beat out. A beat sits in the input register, then the
//  tick logic runs and loads the result register; one beat is taken every
//  cycle while the input is not stalled.
//  The result register is the only thing that throttles the input: a beat is
//  taken while a finished result still waits, and the input stalls only when
//  both registers are full and m_axis_tready is low.
//  Reset clears the timer, the phase and both valid flags and loads the
//  register defaults.

module interval_watering_sequencer_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [9:0] soil_sample, [19:10] standing_water_sample, [23:20] zero
  input  logic [iws_pkg::InDataW-1:0]     s_axis_tdata,
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] valve_open, [1] pump_on, [8:2] moisture_percent,
  // [25:9] seconds_left, [27:26] skip_reason, [31:28] zero
  output logic [iws_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic                            m_axis_tlast,   // cycle_done
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [iws_pkg::AddrW-1:0]       paddr,
  input  logic [iws_pkg::DataW-1:0]       pwdata,
  output logic [iws_pkg::DataW-1:0]       prdata,
  output logic                            pready
);

  localparam int unsigned SW = iws_pkg::SampleW;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic                         auto_en_q;
  logic [iws_pkg::SecW-1:0]     interval_q;
  logic [iws_pkg::DurW-1:0]     duration_q;
  logic [iws_pkg::SettleW-1:0]  settle_q;
  logic [SW-1:0]                water_thr_q;
  logic [iws_pkg::PctW-1:0]     wet_limit_q;

  logic              cfg_wr;
  iws_pkg::cfg_reg_e cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_sel = iws_pkg::cfg_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_en_q   <= 1'b0;
      interval_q  <= iws_pkg::SecW'(60);
      duration_q  <= iws_pkg::DurW'(20000);
      settle_q    <= iws_pkg::SettleW'(2000);
      water_thr_q <= SW'(350);
      wet_limit_q <= iws_pkg::PctW'(70);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        iws_pkg::RegAutoEnable:  auto_en_q   <= pwdata[0];
        iws_pkg::RegInterval:    interval_q  <= pwdata[iws_pkg::SecW-1:0];
        iws_pkg::RegDuration:    duration_q  <= pwdata[iws_pkg::DurW-1:0];
        iws_pkg::RegSettle:      settle_q    <= pwdata[iws_pkg::SettleW-1:0];
        iws_pkg::RegWaterThresh: water_thr_q <= pwdata[SW-1:0];
        iws_pkg::RegWetLimit:    wet_limit_q <= pwdata[iws_pkg::PctW-1:0];
        default: ;  // unmapped address: drop the write
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_sel)
      iws_pkg::RegAutoEnable:  prdata = iws_pkg::DataW'(auto_en_q);
      iws_pkg::RegInterval:    prdata = iws_pkg::DataW'(interval_q);
      iws_pkg::RegDuration:    prdata = iws_pkg::DataW'(duration_q);
      iws_pkg::RegSettle:      prdata = iws_pkg::DataW'(settle_q);
      iws_pkg::RegWaterThresh: prdata = iws_pkg::DataW'(water_thr_q);
      iws_pkg::RegWetLimit:    prdata = iws_pkg::DataW'(wet_limit_q);
      default:                 prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input register and handshake
  // --------------------------------------------------------------------------
  logic          in_vld_q;
  logic [SW-1:0] soil_q;
  logic [SW-1:0] water_q;
  logic          out_vld_q;
  logic          advance;   // result register can take the tick in flight
  logic          fire;      // tick is processed this cycle

  assign advance       = !out_vld_q || m_axis_tready;
  assign fire          = in_vld_q && advance;
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      soil_q  <= s_axis_tdata[SW-1:0];
      water_q <= s_axis_tdata[2*SW-1:SW];
    end
  end

  // --------------------------------------------------------------------------
  // Tick logic
  // --------------------------------------------------------------------------
  // Time since last watering is kept as whole seconds plus a millisecond
  // sub-count, so the due compare and the seconds-left figure need no divide.
  logic [iws_pkg::SecW-1:0] since_s_q, since_s_d;
  logic [iws_pkg::MsW-1:0]  since_ms_q, since_ms_d;
  iws_pkg::phase_e          phase_q, phase_d;
  logic [iws_pkg::DurW-1:0] phase_ms_q, phase_ms_d;

  logic [SW-1:0]                soil, water, soil_off;
  logic [iws_pkg::ProdW-1:0]    pct_prod;
  logic [iws_pkg::PctW-1:0]     pct;
  logic [iws_pkg::SecW-1:0]     s_inc;
  logic [iws_pkg::MsW-1:0]      ms_inc;
  logic                         settle_zero, pump_zero;
  iws_pkg::phase_e              ph_a;
  logic [iws_pkg::DurW-1:0]     pms_a, pms_inc, ph_len;
  logic                         valve, pump, done;
  logic [iws_pkg::SecW-1:0]     secs;
  iws_pkg::skip_e               reason;

  assign soil        = soil_q & iws_pkg::AdcMask;
  assign water       = water_q & iws_pkg::AdcMask;
  assign settle_zero = (settle_q == '0);
  assign pump_zero   = (duration_q == '0);

  // moisture percent, clamped at both ends
  assign soil_off = soil - iws_pkg::DryRaw;
  assign pct_prod = iws_pkg::ProdW'(soil_off) * iws_pkg::ProdW'(iws_pkg::PctRecip);

  always_comb begin
    if (soil <= iws_pkg::DryRaw) begin
      pct = '0;
    end else if (soil >= iws_pkg::WetRaw) begin
      pct = iws_pkg::FullPct;
    end else begin
      pct = pct_prod[iws_pkg::PctShift +: iws_pkg::PctW];
    end
  end

  // advance the idle timer by one millisecond
  always_comb begin
    if (since_ms_q == iws_pkg::MsLast) begin
      ms_inc = '0;
      s_inc  = since_s_q + iws_pkg::SecW'(1);
    end else begin
      ms_inc = since_ms_q + iws_pkg::MsW'(1);
      s_inc  = since_s_q;
    end
  end

  always_comb begin
    since_s_d  = since_s_q;
    since_ms_d = since_ms_q;
    secs       = '0;
    reason     = iws_pkg::SkipNone;
    done       = 1'b0;
    valve      = 1'b0;
    pump       = 1'b0;
    ph_a       = phase_q;
    pms_a      = phase_ms_q;

    // idle: run the interval timer, check the due tick
    if (phase_q == iws_pkg::PhIdle) begin
      if (!auto_en_q) begin
        since_s_d  = '0;
        since_ms_d = '0;
        secs       = interval_q;
      end else if (s_inc >= interval_q) begin
        since_s_d  = '0;
        since_ms_d = '0;
        if (pct >= wet_limit_q) begin
          reason = iws_pkg::SkipWet;
        end else if (water > water_thr_q) begin
          reason = iws_pkg::SkipStanding;
        end else begin
          ph_a  = iws_pkg::next_phase(iws_pkg::PhIdle, settle_zero, pump_zero);
          pms_a = '0;
          if (ph_a == iws_pkg::PhIdle) done = 1'b1;
        end
      end else begin
        since_s_d  = s_inc;
        since_ms_d = ms_inc;
        // floor((interval*1000 - since) / 1000)
        secs = interval_q - s_inc - iws_pkg::SecW'(ms_inc != '0);
      end
    end

    // sequence: the due tick already counts as the first millisecond
    pms_inc = pms_a + iws_pkg::DurW'(1);
    ph_len  = (ph_a == iws_pkg::PhPump) ? duration_q : iws_pkg::DurW'(settle_q);
    phase_d    = ph_a;
    phase_ms_d = pms_a;
    if (ph_a != iws_pkg::PhIdle) begin
      valve = 1'b1;
      pump  = (ph_a == iws_pkg::PhPump);
      if (pms_inc >= ph_len) begin
        phase_d    = iws_pkg::next_phase(ph_a, settle_zero, pump_zero);
        phase_ms_d = '0;
        if (phase_d == iws_pkg::PhIdle) begin
          done       = 1'b1;
          since_s_d  = '0;
          since_ms_d = '0;
        end
      end else begin
        phase_ms_d = pms_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      since_s_q  <= '0;
      since_ms_q <= '0;
      phase_q    <= iws_pkg::PhIdle;
      phase_ms_q <= '0;
    end else if (fire) begin
      since_s_q  <= since_s_d;
      since_ms_q <= since_ms_d;
      phase_q    <= phase_d;
      phase_ms_q <= phase_ms_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      m_axis_tdata <= {4'b0000, reason, secs, pct, pump, valve};
      m_axis_tlast <= done;
    end
  end

  assign m_axis_tvalid = out_vld_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // pump never runs with the valve closed
  a_pump_needs_valve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] || !m_axis_tdata[1]))
    else $error("pump on with valve closed");

  // a skipped cycle is a due tick: no countdown, no drive, no finish
  a_skip_is_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[27:26] != 2'd0) |->
      (m_axis_tdata[25:9] == '0 && !m_axis_tdata[0] && !m_axis_tlast))
    else $error("skip reported outside a due tick");

  // countdown shows only while idle
  a_secs_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[25:9] != '0) |-> !m_axis_tdata[0])
    else $error("seconds left shown while valve open");

  // reason code stays in range
  a_reason_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[27:26] != 2'd3))
    else $error("undefined skip reason");

  // timer is cleared whenever a sequence ends
  a_timer_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && done) |=> (since_s_q == '0 && since_ms_q == '0))
    else $error("timer not restarted after cycle end");

endmodule

@@ tb/interval_watering_sequencer_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interval_watering_sequencer_unit_tb
// Self-checking bench for the watering sequencer. It walks a short directed
// table first: sensor extremes, skip reasons, zero-length phases and
// register extremes. Then it runs random register phases with random tick
// beats. Every result beat is compared with a hand-written result or a
// tick-level predictor of the timer and valve/pump sequence in this bench.
// ----------------------------------------------------------------------------
module interval_watering_sequencer_unit_tb;
  import iws_pkg::*;

  localparam int unsigned RandItems = 1300;  // random tick beats, at least
  localparam int unsigned LongHold  = 60;    // cycles of the long result hold-off

  typedef struct packed {
    logic            valve;
    logic            pump;
    logic [PctW-1:0] pct;
    logic [SecW-1:0] secs;
    skip_e           reason;
    logic            done;
  } tick_out_t;

  typedef enum bit {RowTick, RowWrite} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    cfg_reg_e             reg_idx;
    logic [DataW-1:0]     value;
    logic [SampleW-1:0]   soil;
    logic [SampleW-1:0]   water;
    bit                   typed;    // want holds a hand-written result
    tick_out_t            want;
  } step_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [DataW-1:0]    pwdata = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;

  // Register image, at reset values.
  logic                cfg_en       = 1'b0;
  logic [SecW-1:0]     cfg_interval = SecW'(60);
  logic [DurW-1:0]     cfg_duration = DurW'(20000);
  logic [SettleW-1:0]  cfg_settle   = SettleW'(2000);
  logic [SampleW-1:0]  cfg_thresh   = SampleW'(350);
  logic [PctW-1:0]     cfg_wet      = PctW'(70);

  // Sequencer state as the predictor sees it.
  logic [26:0]         elapsed_ms    = '0;
  phase_e              seq_phase     = PhIdle;
  logic [DurW-1:0]     phase_elapsed = '0;

  tick_out_t           expected_ticks [$];
  int unsigned         mismatch_count = 0;
  bit                  no_idle = 1'b0;        // both sides run without gaps
  bit                  long_hold_req = 1'b0;  // ask the sink for one long hold-off

  interval_watering_sequencer_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [9:0] soil, [19:10] standing water
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [0] valve, [1] pump, [8:2] pct, [25:9] secs,
                                     // [27:26] skip reason
    .m_axis_tlast  (m_axis_tlast),   // cycle done
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Length of a sequence phase under the current registers.
  function automatic logic [DurW-1:0] span_of(phase_e p);
    case (p)
      PhPump:          return cfg_duration;
      PhLead, PhTrail: return DurW'(cfg_settle);
      default:         return '0;
    endcase
  endfunction

  // Step to the phase after p, skipping phases of zero length.
  function automatic void enter_after(phase_e p);
    logic [1:0] nx;
    nx = p;
    do nx = nx + 2'd1;
    while (phase_e'(nx) != PhIdle && span_of(phase_e'(nx)) == '0);
    seq_phase     = phase_e'(nx);
    phase_elapsed = '0;
  endfunction

  // One millisecond tick: advance the timer and the sequence, build the result.
  function automatic tick_out_t predict_tick(logic [SampleW-1:0] soil,
                                             logic [SampleW-1:0] water);
    tick_out_t   r;
    int unsigned raw;
    int unsigned pct_v;
    int unsigned interval_ms;
    phase_e      cur;
    r           = '0;
    raw         = soil & AdcMask;
    water       = water & AdcMask;
    interval_ms = cfg_interval * MsPerS;
    // Truncating linear map, clamped at both ends.
    if (raw <= DryRaw) pct_v = 0;
    else if (raw >= WetRaw) pct_v = FullPct;
    else pct_v = ((raw - DryRaw) * FullPct) / (WetRaw - DryRaw);
    r.pct = PctW'(pct_v);

    if (seq_phase == PhIdle) begin
      if (!cfg_en) begin
        // Hold the timer; show the full interval.
        elapsed_ms = '0;
        r.secs     = cfg_interval;
      end else begin
        if (elapsed_ms != '1) elapsed_ms = elapsed_ms + 27'd1;
        if (32'(elapsed_ms) >= interval_ms) begin
          elapsed_ms = '0;
          if (pct_v >= cfg_wet) r.reason = SkipWet;
          else if (water > cfg_thresh) r.reason = SkipStanding;
          else begin
            enter_after(PhIdle);
            // All lengths zero: the sequence is over on the due tick.
            if (seq_phase == PhIdle) r.done = 1'b1;
          end
        end else begin
          r.secs = SecW'((interval_ms - 32'(elapsed_ms)) / MsPerS);
        end
      end
    end

    // The due tick already counts as the first ms of the sequence.
    if (seq_phase != PhIdle) begin
      cur           = seq_phase;
      r.valve       = 1'b1;
      r.pump        = (cur == PhPump);
      phase_elapsed = phase_elapsed + 20'd1;
      if (phase_elapsed >= span_of(cur)) begin
        enter_after(cur);
        if (seq_phase == PhIdle) begin
          r.done     = 1'b1;
          elapsed_ms = '0;
        end
      end
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Rows of the directed table.
  function automatic step_row_t tick_row(logic [SampleW-1:0] soil, logic [SampleW-1:0] water);
    return '{RowTick, RegAutoEnable, 32'd0, soil, water, 1'b0, tick_out_t'('0)};
  endfunction

  function automatic step_row_t checked_row(logic [SampleW-1:0] soil,
                                            logic [SampleW-1:0] water,
                                            logic valve, logic pump,
                                            logic [PctW-1:0] pct, logic [SecW-1:0] secs,
                                            skip_e why, logic done);
    return '{RowTick, RegAutoEnable, 32'd0, soil, water, 1'b1,
             '{valve, pump, pct, secs, why, done}};
  endfunction

  function automatic step_row_t write_row(cfg_reg_e idx, logic [DataW-1:0] value);
    return '{RowWrite, idx, value, 10'd0, 10'd0, 1'b0, tick_out_t'('0)};
  endfunction

  // Offer one tick beat after a random gap; predict it once it is taken.
  task automatic send_tick(input logic [SampleW-1:0] soil, input logic [SampleW-1:0] water,
                           input bit typed, input tick_out_t want);
    int unsigned gap;
    tick_out_t   model_out;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, water, soil};
    do @(posedge clk_i); while (!s_axis_tready);
    model_out = predict_tick(soil, water);
    expected_ticks.push_back(typed ? want : model_out);
  endtask

  // Drop valid and wait until every predicted result has come out.
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_ticks.size() != 0);
  endtask

  // Setup and access cycle; mirror the write into the register image.
  task automatic write_reg(input cfg_reg_e idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegAutoEnable:  cfg_en       = value[0];
      RegInterval:    cfg_interval = value[SecW-1:0];
      RegDuration:    cfg_duration = value[DurW-1:0];
      RegSettle:      cfg_settle   = value[SettleW-1:0];
      RegWaterThresh: cfg_thresh   = value[SampleW-1:0];
      RegWetLimit:    cfg_wet      = value[PctW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Result sink: check each beat, then hold ready low for a drawn stall.
  initial begin : result_sink
    int unsigned hold_left;
    tick_out_t   want;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_ticks.size() == 0) begin
          $error("result beat with no tick pending");
          mismatch_count++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("valve_open", want.valve, m_axis_tdata[0]);
          check_field("pump_on", want.pump, m_axis_tdata[1]);
          check_field("moisture_percent", want.pct, m_axis_tdata[8:2]);
          check_field("seconds_left", want.secs, m_axis_tdata[25:9]);
          check_field("skip_reason", want.reason, m_axis_tdata[27:26]);
          check_field("cycle_done", want.done, m_axis_tlast);
        end
        if (long_hold_req) begin
          hold_left     = LongHold;
          long_hold_req = 1'b0;
        end else begin
          hold_left = no_idle ? 0 : $urandom_range(0, 5);
        end
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    step_row_t          dir_rows [39];
    int unsigned        sent;
    int unsigned        n_items;
    int unsigned        sel;
    bit                 dry;
    logic               en;
    logic [SecW-1:0]    ival;
    logic [SettleW-1:0] settle;
    logic [DurW-1:0]    dur;
    logic [SampleW-1:0] thresh;
    logic [PctW-1:0]    wet;
    logic [SampleW-1:0] soil;
    logic [SampleW-1:0] water;

    dir_rows = '{
      // Auto off after reset: timer held, full interval shown.
      checked_row(10'd0, 10'd0, 1'b0, 1'b0, 7'd0, 17'd60, SkipNone, 1'b0),
      checked_row(10'd1023, 10'd1023, 1'b0, 1'b0, 7'd100, 17'd60, SkipNone, 1'b0),
      checked_row(10'd300, 10'd512, 1'b0, 1'b0, 7'd0, 17'd60, SkipNone, 1'b0),
      tick_row(10'd301, 10'd0),
      checked_row(10'd879, 10'd0, 1'b0, 1'b0, 7'd99, 17'd60, SkipNone, 1'b0),
      checked_row(10'd880, 10'd0, 1'b0, 1'b0, 7'd100, 17'd60, SkipNone, 1'b0),
      tick_row(10'd590, 10'd700),
      // Zero interval, all lengths zero: due every tick, done at once.
      write_row(RegAutoEnable, 32'd1),
      write_row(RegInterval, 32'd0),
      write_row(RegSettle, 32'd0),
      write_row(RegDuration, 32'd0),
      checked_row(10'd0, 10'd0, 1'b0, 1'b0, 7'd0, 17'd0, SkipNone, 1'b1),
      checked_row(10'd1023, 10'd0, 1'b0, 1'b0, 7'd100, 17'd0, SkipWet, 1'b0),
      checked_row(10'd0, 10'd351, 1'b0, 1'b0, 7'd0, 17'd0, SkipStanding, 1'b0),
      checked_row(10'd0, 10'd350, 1'b0, 1'b0, 7'd0, 17'd0, SkipNone, 1'b1),
      // Wet limit above 100 never skips; zero always skips.
      write_row(RegWetLimit, 32'd127),
      checked_row(10'd1023, 10'd0, 1'b0, 1'b0, 7'd100, 17'd0, SkipNone, 1'b1),
      write_row(RegWetLimit, 32'd0),
      checked_row(10'd0, 10'd1023, 1'b0, 1'b0, 7'd0, 17'd0, SkipWet, 1'b0),
      write_row(RegWetLimit, 32'd100),
      write_row(RegWaterThresh, 32'd1023),
      checked_row(10'd879, 10'd1023, 1'b0, 1'b0, 7'd99, 17'd0, SkipNone, 1'b1),
      write_row(RegWaterThresh, 32'd0),
      checked_row(10'd0, 10'd1, 1'b0, 1'b0, 7'd0, 17'd0, SkipStanding, 1'b0),
      checked_row(10'd0, 10'd0, 1'b0, 1'b0, 7'd0, 17'd0, SkipNone, 1'b1),
      // Short full sequence: lead 2, pump 3, trail 2 ticks.
      write_row(RegSettle, 32'd2),
      write_row(RegDuration, 32'd3),
      write_row(RegWaterThresh, 32'd1023),
      tick_row(10'd100, 10'd1023),
      tick_row(10'd512, 10'd5),
      tick_row(10'd880, 10'd0),
      tick_row(10'd301, 10'd1000),
      tick_row(10'd879, 10'd2),
      tick_row(10'd1023, 10'd1023),
      tick_row(10'd0, 10'd0),
      // Largest interval, counting and then held.
      write_row(RegInterval, 32'd131071),
      checked_row(10'd0, 10'd0, 1'b0, 1'b0, 7'd0, 17'd131070, SkipNone, 1'b0),
      write_row(RegAutoEnable, 32'd0),
      checked_row(10'd1023, 10'd0, 1'b0, 1'b0, 7'd100, 17'd131071, SkipNone, 1'b0)
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == RowWrite) begin
        wait_results_drained();
        write_reg(dir_rows[k].reg_idx, dir_rows[k].value);
      end else begin
        send_tick(dir_rows[k].soil, dir_rows[k].water, dir_rows[k].typed, dir_rows[k].want);
      end
    end

    // Random phases. The first runs a one-second interval long enough to come
    // due; the rest mostly use zero or short intervals and short phases so
    // that many sequences complete, with register extremes mixed in.
    sent = 0;
    for (int unsigned ph = 0; sent < RandItems; ph++) begin
      en  = (ph == 0) || ($urandom_range(0, 6) != 0);
      sel = $urandom_range(0, 19);
      if (ph == 0) ival = SecW'(1);
      else if (sel < 10) ival = '0;
      else if (sel < 13) ival = SecW'(1);
      else if (sel < 15) ival = SecW'($urandom_range(2, 5));
      else if (sel < 17) ival = '1;
      else if (sel < 18) ival = SecW'(86400);
      else ival = SecW'($urandom_range(0, 131071));
      sel = $urandom_range(0, 19);
      if (sel < 14 || ph == 0) settle = SettleW'($urandom_range(0, 4));
      else if (sel < 16) settle = '1;
      else if (sel < 18) settle = SettleW'(2000);
      else settle = SettleW'($urandom_range(0, 65535));
      sel = $urandom_range(0, 19);
      if (sel < 14 || ph == 0) dur = DurW'($urandom_range(0, 6));
      else if (sel < 16) dur = '1;
      else if (sel < 18) dur = DurW'(1000);
      else dur = DurW'($urandom_range(0, 1048575));
      sel = $urandom_range(0, 9);
      if (sel < 2) thresh = '0;
      else if (sel < 4) thresh = '1;
      else thresh = SampleW'($urandom_range(0, 1023));
      sel = $urandom_range(0, 9);
      if (sel < 2) wet = '0;
      else if (sel < 4) wet = PctW'(100);
      else if (sel < 5) wet = '1;
      else wet = PctW'($urandom_range(0, 127));

      // Registers change only with nothing in flight; a running sequence
      // carries on under the new lengths.
      wait_results_drained();
      write_reg(RegAutoEnable, 32'(en));
      write_reg(RegInterval, 32'(ival));
      write_reg(RegDuration, 32'(dur));
      write_reg(RegSettle, 32'(settle));
      write_reg(RegWaterThresh, 32'(thresh));
      write_reg(RegWetLimit, 32'(wet));

      n_items = (ph == 0) ? 1010 : $urandom_range(40, 120);
      dry     = ($urandom_range(0, 4) < 3);
      for (int unsigned i = 0; i < n_items; i++) begin
        if (i % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
        // Stall the sink for a long stretch while ticks keep coming, so
        // the block fills up and pushes back on its input.
        if (ph == 0 && i == 300) long_hold_req = 1'b1;
        // Pause the source until every result is out.
        if (ph == 0 && i == 600) wait_results_drained();
        soil  = SampleW'($urandom_range(0, 1023));
        water = SampleW'($urandom_range(0, 1023));
        // Dry soil and little standing water let most due ticks water.
        if (dry && $urandom_range(0, 3) != 0) begin
          soil  = SampleW'($urandom_range(0, 500));
          water = SampleW'($urandom_range(0, thresh));
        end
        send_tick(soil, water, 1'b0, tick_out_t'('0));
      end
      sent += n_items;
    end

    wait_results_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
design/iws_pkg.sv
design/interval_watering_sequencer_unit.sv
tb/interval_watering_sequencer_unit_tb.sv
